// File: src/ppt_pkg.sv
// Shared types and constants for the point-in-polygon test block.
`default_nettype none

package ppt_pkg;

    localparam int SLOT_W  = 4;
    localparam int VCNT_W  = 5;
    localparam int CROSS_W = 5;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_TEST  = 1'b1
    } t_cmd;

    typedef struct packed {
        logic               valid;
        t_cmd               cmd;
        logic [SLOT_W-1:0]  slot;
    } t_tok_ctl;

endpackage

`default_nettype wire

// File: src/ppt_if.sv
// Handshake channels of the point-in-polygon test block.
`default_nettype none

interface ppt_in_if #(parameter int W = 16);
    logic                        valid;
    logic                        ready;
    ppt_pkg::t_cmd               command;
    logic [ppt_pkg::SLOT_W-1:0]  vertex_slot;
    logic signed [W-1:0]         coord_x;
    logic signed [W-1:0]         coord_y;

    modport source (output valid, command, vertex_slot, coord_x, coord_y, input ready);
    modport sink   (input valid, command, vertex_slot, coord_x, coord_y, output ready);
endinterface

interface ppt_out_if;
    logic                         valid;
    logic                         ready;
    logic                         inside_res;
    logic [ppt_pkg::CROSS_W-1:0]  crossing_count;

    modport source (output valid, inside_res, crossing_count, input ready);
    modport sink   (input valid, inside_res, crossing_count, output ready);
endinterface

interface ppt_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [ppt_pkg::VCNT_W-1:0]  vertex_count;

    modport source (output valid, vertex_count, input ready);
    modport sink   (input valid, vertex_count, output ready);
endinterface

`default_nettype wire

// File: src/ppt_edge.sv
// Exact crossing test of one polygon edge against a rightward ray.
`default_nettype none

module ppt_edge #(
    parameter int W = 16
) (
    input  wire logic                i_en,
    input  wire logic signed [W-1:0] i_bx,
    input  wire logic signed [W-1:0] i_by,
    input  wire logic signed [W-1:0] i_ex,
    input  wire logic signed [W-1:0] i_ey,
    input  wire logic signed [W-1:0] i_px,
    input  wire logic signed [W-1:0] i_py,
    output logic                     o_hit
);
    localparam int DW = W + 1;
    localparam int PW = 2 * W + 2;

    logic signed [DW-1:0] t_raw;
    logic signed [DW-1:0] d_raw;
    logic signed [DW-1:0] t_pos;
    logic signed [DW-1:0] d_pos;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] qx;
    logic signed [PW-1:0] lhs;
    logic signed [PW-1:0] rhs;
    logic                 in_span;

    always_comb begin
        t_raw = DW'(i_py) - DW'(i_by);
        d_raw = DW'(i_ey) - DW'(i_by);
        dx    = DW'(i_ex) - DW'(i_bx);
        qx    = DW'(i_px) - DW'(i_bx);
        if (d_raw < 0) begin
            t_pos = -t_raw;
            d_pos = -d_raw;
        end else begin
            t_pos = t_raw;
            d_pos = d_raw;
        end
        lhs = PW'(t_pos) * PW'(dx);
        rhs = PW'(qx) * PW'(d_pos);
        if (i_by < i_ey) begin
            in_span = (i_py >= i_by) && (i_py < i_ey);
        end else if (i_ey < i_by) begin
            in_span = (i_py >= i_ey) && (i_py < i_by);
        end else begin
            in_span = 1'b0;
        end
        o_hit = i_en && in_span && (lhs > rhs);
    end

endmodule

`default_nettype wire

// File: src/ppt_cell.sv
// One chain cell: stores one vertex and, unless it is the first or an unused cell, tests the edge ending at it.
`default_nettype none

module ppt_cell #(
    parameter int W   = 16,
    parameter int NW  = 5,
    parameter int IDX = 0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic [NW-1:0]         i_n,
    input  wire ppt_pkg::t_tok_ctl     i_ctl,
    input  wire logic signed [W-1:0]   i_px,
    input  wire logic signed [W-1:0]   i_py,
    input  wire logic signed [W-1:0]   i_v0x,
    input  wire logic signed [W-1:0]   i_v0y,
    input  wire logic signed [W-1:0]   i_prx,
    input  wire logic signed [W-1:0]   i_pry,
    input  wire logic [NW-1:0]         i_cnt,
    output ppt_pkg::t_tok_ctl          o_ctl,
    output logic signed [W-1:0]        o_px,
    output logic signed [W-1:0]        o_py,
    output logic signed [W-1:0]        o_v0x,
    output logic signed [W-1:0]        o_v0y,
    output logic signed [W-1:0]        o_prx,
    output logic signed [W-1:0]        o_pry,
    output logic [NW-1:0]              o_cnt
);
    import ppt_pkg::*;

    localparam bit FIRST = (IDX == 0);

    logic signed [W-1:0] r_vx;
    logic signed [W-1:0] r_vy;
    t_tok_ctl            r_ctl;
    logic signed [W-1:0] r_px;
    logic signed [W-1:0] r_py;
    logic signed [W-1:0] r_v0x;
    logic signed [W-1:0] r_v0y;
    logic signed [W-1:0] r_prx;
    logic signed [W-1:0] r_pry;
    logic [NW-1:0]       r_cnt;

    logic signed [W-1:0] n_v0x;
    logic signed [W-1:0] n_v0y;
    logic signed [W-1:0] n_prx;
    logic signed [W-1:0] n_pry;
    logic [NW-1:0]       n_cnt;

    logic use_cell;
    logic is_test;
    logic wr;
    logic hit;

    assign use_cell = NW'(IDX) < i_n;
    assign is_test  = i_ctl.valid && (i_ctl.cmd == CMD_TEST);
    assign wr       = i_en && i_ctl.valid && (i_ctl.cmd == CMD_WRITE)
                      && (NW'(i_ctl.slot) == NW'(IDX));

    ppt_edge #(.W(W)) u_edge (
        .i_en  (is_test && use_cell && !FIRST),
        .i_bx  (i_prx),
        .i_by  (i_pry),
        .i_ex  (r_vx),
        .i_ey  (r_vy),
        .i_px  (i_px),
        .i_py  (i_py),
        .o_hit (hit)
    );

    always_comb begin
        if (FIRST) begin
            n_v0x = r_vx;
            n_v0y = r_vy;
            n_prx = r_vx;
            n_pry = r_vy;
            n_cnt = '0;
        end else begin
            n_v0x = i_v0x;
            n_v0y = i_v0y;
            n_prx = use_cell ? r_vx : i_prx;
            n_pry = use_cell ? r_vy : i_pry;
            n_cnt = i_cnt + NW'(hit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_vx <= i_px;
            r_vy <= i_py;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px  <= i_px;
            r_py  <= i_py;
            r_v0x <= n_v0x;
            r_v0y <= n_v0y;
            r_prx <= n_prx;
            r_pry <= n_pry;
            r_cnt <= n_cnt;
        end
    end

    assign o_ctl = r_ctl;
    assign o_px  = r_px;
    assign o_py  = r_py;
    assign o_v0x = r_v0x;
    assign o_v0y = r_v0y;
    assign o_prx = r_prx;
    assign o_pry = r_pry;
    assign o_cnt = r_cnt;

    a_prev_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && is_test && !use_cell && !FIRST) |=> (r_prx === $past(i_prx)))
        else $error("Unused cell altered the previous vertex.");

endmodule

`default_nettype wire

// File: src/ppt_close.sv
// Closing-edge stage and result register of the point-in-polygon test.
`default_nettype none

module ppt_close #(
    parameter int W  = 16,
    parameter int NW = 5
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic [NW-1:0]                  i_n,
    input  wire ppt_pkg::t_tok_ctl              i_ctl,
    input  wire logic signed [W-1:0]            i_px,
    input  wire logic signed [W-1:0]            i_py,
    input  wire logic signed [W-1:0]            i_v0x,
    input  wire logic signed [W-1:0]            i_v0y,
    input  wire logic signed [W-1:0]            i_prx,
    input  wire logic signed [W-1:0]            i_pry,
    input  wire logic [NW-1:0]                  i_cnt,
    output logic                                o_valid,
    output logic                                o_inside,
    output logic [ppt_pkg::CROSS_W-1:0]         o_cnt
);
    import ppt_pkg::*;

    logic              r_valid;
    logic              r_inside;
    logic [CROSS_W-1:0] r_cnt;
    logic [NW-1:0]     n_total;
    logic              is_test;
    logic              hit;

    assign is_test = i_ctl.valid && (i_ctl.cmd == CMD_TEST);

    ppt_edge #(.W(W)) u_edge (
        .i_en  (is_test && (i_n != '0)),
        .i_bx  (i_prx),
        .i_by  (i_pry),
        .i_ex  (i_v0x),
        .i_ey  (i_v0y),
        .i_px  (i_px),
        .i_py  (i_py),
        .o_hit (hit)
    );

    assign n_total = i_cnt + NW'(hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= is_test;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_inside <= n_total[0];
            r_cnt    <= n_total[CROSS_W-1:0];
        end
    end

    assign o_valid  = r_valid;
    assign o_inside = r_inside;
    assign o_cnt    = r_cnt;

endmodule

`default_nettype wire

// File: src/point_in_polygon_test.sv
// Top level of the point-in-polygon test by ray casting over a chain of vertex cells.
//
// Words arrive on i_in. A word with command write stores its coordinates in the
// vertex slot it names and gives no result. A word with command test casts a ray
// from the point toward +x and gives one word on o_out: the crossing count and its
// parity as inside_res. The polygon uses the first vertex_count slots; the user
// writes vertex_count on i_cfg while the block is idle, which the block does not
// enforce. A count above MAX_VERTICES acts as MAX_VERTICES. Every word travels
// down a row of MAX_VERTICES cells, one cell per cycle, and one word is accepted
// per cycle; when the receiver stalls with a result waiting, the whole row holds
// and i_in.ready drops. Each cell holds one vertex, and each used cell after the
// first checks the edge that ends at it; a last stage checks the closing edge and
// loads the output register. Writes travel the same row, so each test sees exactly
// the vertices written before it. Reset empties the row, drops the output and sets
// vertex_count to zero; vertex slots keep no reset value.
`default_nettype none

module point_in_polygon_test #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_WIDTH  = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ppt_in_if.sink      i_in,
    ppt_out_if.source   o_out,
    ppt_cfg_if.sink     i_cfg
);
    import ppt_pkg::*;

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int NW = (CW > VCNT_W) ? CW : VCNT_W;

    logic [VCNT_W-1:0] r_vcount;
    logic [NW-1:0]     w_nsat;
    logic              w_en;
    logic              w_out_valid;

    t_tok_ctl                 w_ctl [0:MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] w_px  [0:MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] w_py  [0:MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] w_v0x [0:MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] w_v0y [0:MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] w_prx [0:MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] w_pry [0:MAX_VERTICES];
    logic [NW-1:0]            w_cnt [0:MAX_VERTICES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= '0;
        end else if (i_cfg.valid) begin
            r_vcount <= i_cfg.vertex_count;
        end
    end

    assign i_cfg.ready = 1'b1;
    assign w_nsat = (NW'(r_vcount) > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(r_vcount);

    assign w_en       = !w_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    assign w_ctl[0].valid = i_in.valid;
    assign w_ctl[0].cmd   = i_in.command;
    assign w_ctl[0].slot  = i_in.vertex_slot;
    assign w_px[0]  = i_in.coord_x;
    assign w_py[0]  = i_in.coord_y;
    assign w_v0x[0] = '0;
    assign w_v0y[0] = '0;
    assign w_prx[0] = '0;
    assign w_pry[0] = '0;
    assign w_cnt[0] = '0;

    for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
        ppt_cell #(.W(COORD_WIDTH), .NW(NW), .IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_n     (w_nsat),
            .i_ctl   (w_ctl[g]),
            .i_px    (w_px[g]),
            .i_py    (w_py[g]),
            .i_v0x   (w_v0x[g]),
            .i_v0y   (w_v0y[g]),
            .i_prx   (w_prx[g]),
            .i_pry   (w_pry[g]),
            .i_cnt   (w_cnt[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_px    (w_px[g+1]),
            .o_py    (w_py[g+1]),
            .o_v0x   (w_v0x[g+1]),
            .o_v0y   (w_v0y[g+1]),
            .o_prx   (w_prx[g+1]),
            .o_pry   (w_pry[g+1]),
            .o_cnt   (w_cnt[g+1])
        );
    end

    ppt_close #(.W(COORD_WIDTH), .NW(NW)) u_close (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_n      (w_nsat),
        .i_ctl    (w_ctl[MAX_VERTICES]),
        .i_px     (w_px[MAX_VERTICES]),
        .i_py     (w_py[MAX_VERTICES]),
        .i_v0x    (w_v0x[MAX_VERTICES]),
        .i_v0y    (w_v0y[MAX_VERTICES]),
        .i_prx    (w_prx[MAX_VERTICES]),
        .i_pry    (w_pry[MAX_VERTICES]),
        .i_cnt    (w_cnt[MAX_VERTICES]),
        .o_valid  (w_out_valid),
        .o_inside (o_out.inside_res),
        .o_cnt    (o_out.crossing_count)
    );

    assign o_out.valid = w_out_valid;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl[MAX_VERTICES].valid && w_ctl[MAX_VERTICES].cmd == CMD_TEST)
        |-> (w_cnt[MAX_VERTICES] <= NW'(MAX_VERTICES - 1)))
        else $error("Crossing count exceeds the number of cell edges.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_ctl[MAX_VERTICES]))
        else $error("Cell row advanced while the output was stalled.");

    a_result_from_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(w_out_valid) |->
        $past(w_ctl[MAX_VERTICES].valid && w_ctl[MAX_VERTICES].cmd == CMD_TEST))
        else $error("Result produced without a test word at the end of the row.");

endmodule

`default_nettype wire
